// ===== hdl/dhc_pkg.sv =====
// package: constants, types and helpers for the drift hit calibration unit
`default_nettype none
package dhc_pkg;

  localparam int LAYERS      = 32;
  localparam int WIRES       = 256;
  localparam int POLY_TERMS  = 6;
  localparam int FRAC_BITS   = 16;

  localparam int TBL_WORDS   = POLY_TERMS + 3;
  localparam int SLOT_SHIFT  = POLY_TERMS;
  localparam int SLOT_OFFSET = POLY_TERMS + 1;
  localparam int SLOT_HALF   = POLY_TERMS + 2;
  localparam int LT_AW       = $clog2(LAYERS);
  localparam int WO_AW       = $clog2(LAYERS * WIRES);

  // setup stages, horner steps (multiply + accumulate each), clamp stage
  localparam int HRN_FIRST   = 4;
  localparam int NSTG        = HRN_FIRST + 2 * (POLY_TERMS - 1) + 1;

  localparam int LAYER_INNER_MAX  = 4;
  localparam int LAYER_MIDDLE_MAX = 10;
  localparam int LAYER_OUTER_MAX  = 16;

  localparam logic [2:0] REG_CUT_MIN    = 3'd0;
  localparam logic [2:0] REG_CUT_INNER  = 3'd1;
  localparam logic [2:0] REG_CUT_MIDDLE = 3'd2;
  localparam logic [2:0] REG_CUT_OUTER  = 3'd3;
  localparam logic [2:0] REG_TOT_MIN    = 3'd4;
  localparam logic [2:0] REG_NS_COUNT   = 3'd5;

  typedef enum logic [1:0] {
    FUNC_HIT  = 2'd0,
    FUNC_TBL  = 2'd1,
    FUNC_WIRE = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef logic [TBL_WORDS-1:0][31:0] tbl_row_t;

  typedef struct packed {
    logic               lay_ok;
    logic               wire_ok;
    logic               hv;
    logic [4:0]         layer;
    logic [20:0]        rel;
    logic [20:0]        tot;
    logic signed [31:0] t0;
    logic signed [33:0] offs;
    logic signed [63:0] prod;
    logic signed [31:0] dt;
    logic signed [31:0] x;
    logic signed [31:0] acc;
  } stg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/drift_hit_calibration_unit.sv =====
// top level: pipelined drift chamber hit calibration with table stores
//
// Hits stream in at one beat per clock while the pipeline advances and leave
// in order through NSTG register stages (15 with six polynomial terms). The
// stages are an input stage that also reads both stores, one stage for window
// cuts, drift time product and offset sum, one to saturate drift time, one for
// the time shift, two per horner step (32x32 multiply, then round, add,
// saturate) and one clamp stage. The whole pipeline advances together whenever
// the output register is empty or being taken, so a stalled consumer freezes
// it with nothing lost. Table and wire offset writes are performed at their
// accept edge and give no result; a hit accepted after a write sees it. Stores
// have no reset and must be written before a hit reads them. Registers must be
// written over the apb port only while no hit is in flight; the block itself
// does not enforce this.
`default_nettype none
module drift_hit_calibration_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [4:0]  layer_i,
  input  wire logic [7:0]  wire_req_i,
  input  wire logic [19:0] leading_raw_i,
  input  wire logic [19:0] trailing_raw_i,
  input  wire logic [19:0] reference_time_i,
  input  wire logic [31:0] event_t0_i,
  input  wire logic [3:0]  table_slot_i,
  input  wire logic [31:0] table_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             hit_valid_o,
  output logic [20:0]      relative_leading_o,
  output logic [20:0]      time_over_threshold_o,
  output logic [31:0]      drift_ns_o,
  output logic [30:0]      drift_length_o
);
  import dhc_pkg::*;

  localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

  // configuration registers
  logic [20:0] cut_min_q, cut_inner_q, cut_middle_q, cut_outer_q, tot_min_q;
  logic [30:0] npc_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_min_q    <= '0;
      cut_inner_q  <= 21'd1048575;
      cut_middle_q <= 21'd1048575;
      cut_outer_q  <= 21'd1048575;
      tot_min_q    <= '0;
      npc_q        <= 31'd65536;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_CUT_MIN:    cut_min_q    <= pwdata[20:0];
        REG_CUT_INNER:  cut_inner_q  <= pwdata[20:0];
        REG_CUT_MIDDLE: cut_middle_q <= pwdata[20:0];
        REG_CUT_OUTER:  cut_outer_q  <= pwdata[20:0];
        REG_TOT_MIN:    tot_min_q    <= pwdata[20:0];
        REG_NS_COUNT:   npc_q        <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_CUT_MIN:    prdata = {11'd0, cut_min_q};
      REG_CUT_INNER:  prdata = {11'd0, cut_inner_q};
      REG_CUT_MIDDLE: prdata = {11'd0, cut_middle_q};
      REG_CUT_OUTER:  prdata = {11'd0, cut_outer_q};
      REG_TOT_MIN:    prdata = {11'd0, tot_min_q};
      REG_NS_COUNT:   prdata = {1'b0, npc_q};
      default:        prdata = '0;
    endcase
  end

  // global advance: output register empty or being drained
  logic en, acc_beat;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign acc_beat   = in_valid_i && en;

  // stores: one table row per layer, one offset per wire
  tbl_row_t    lt_mem [LAYERS];
  logic [31:0] wo_mem [LAYERS*WIRES];
  logic [WO_AW-1:0] wo_addr;
  logic        lay_ok, wire_ok;

  assign lay_ok  = int'(layer_i) < LAYERS;
  assign wire_ok = int'(wire_req_i) < WIRES;
  assign wo_addr = WO_AW'(int'(layer_i) * WIRES + int'(wire_req_i));

  tbl_row_t    row_q [NSTG];
  logic [31:0] woff_q;

  // pipeline
  stg_t     stg_q [NSTG];
  stg_t     stg_d [NSTG];
  tbl_row_t row_d [NSTG];
  logic     vld_q [NSTG];

  // store writes, store reads and the table row that rides with each stage
  always_ff @(posedge clk_i) begin
    if (acc_beat && func_i == FUNC_TBL && lay_ok && int'(table_slot_i) < TBL_WORDS)
      lt_mem[layer_i[LT_AW-1:0]][table_slot_i] <= table_data_i;
    if (acc_beat && func_i == FUNC_WIRE && lay_ok && wire_ok)
      wo_mem[wo_addr] <= table_data_i;
    if (en) begin
      row_q[0] <= lt_mem[layer_i[LT_AW-1:0]];
      woff_q   <= wo_mem[wo_addr];
      for (int k = 1; k < NSTG; k++) row_q[k] <= row_d[k];
    end
  end

  always_comb begin
    logic signed [52:0] p;
    logic signed [63:0] t;
    logic signed [31:0] lmax, half;
    int                 ci;
    stg_d[0]         = '0;
    stg_d[0].lay_ok  = lay_ok;
    stg_d[0].wire_ok = wire_ok;
    stg_d[0].layer   = layer_i;
    stg_d[0].rel     = {1'b0, leading_raw_i} - {1'b0, reference_time_i};
    stg_d[0].tot     = {1'b0, trailing_raw_i} - {1'b0, leading_raw_i};
    stg_d[0].t0      = event_t0_i;
    row_d[0]         = '0;
    for (int k = 1; k < NSTG; k++) begin
      stg_d[k] = stg_q[k-1];
      row_d[k] = row_q[k-1];
    end

    // stage 1: cuts, product, offset sum; missing layer or wire reads zero
    if (!stg_q[0].lay_ok) row_d[1] = '0;
    if (stg_q[0].layer <= 5'(LAYER_INNER_MAX)) lmax = 32'(signed'(cut_inner_q));
    else if (stg_q[0].layer <= 5'(LAYER_MIDDLE_MAX)) lmax = 32'(signed'(cut_middle_q));
    else lmax = 32'(signed'(cut_outer_q));
    stg_d[1].hv = (signed'(stg_q[0].tot) >= signed'(tot_min_q));
    if (stg_q[0].layer <= 5'(LAYER_OUTER_MAX) &&
        (signed'(stg_q[0].rel) < signed'(cut_min_q) ||
         32'(signed'(stg_q[0].rel)) > lmax))
      stg_d[1].hv = 1'b0;
    p = signed'(stg_q[0].rel) * signed'({1'b0, npc_q});
    stg_d[1].prod = 64'(p);
    stg_d[1].offs = 34'(signed'(stg_q[0].t0))
                  + 34'(signed'(row_d[1][SLOT_OFFSET]))
                  + ((stg_q[0].lay_ok && stg_q[0].wire_ok) ? 34'(signed'(woff_q)) : 34'sd0);

    // stage 2: saturated drift time
    stg_d[2].dt = sat32(stg_q[1].prod - 64'(stg_q[1].offs));

    // stage 3: time shift, seed accumulator with top coefficient
    stg_d[3].x   = sat32(64'(stg_q[2].dt) - 64'(signed'(row_d[3][SLOT_SHIFT])));
    stg_d[3].acc = signed'(row_d[3][POLY_TERMS-1]);

    // horner steps
    for (int k = HRN_FIRST; k < NSTG - 1; k++) begin
      ci = POLY_TERMS - 2 - ((k - HRN_FIRST) >> 1);
      if (((k - HRN_FIRST) & 1) == 0) begin
        stg_d[k].prod = stg_q[k-1].acc * stg_q[k-1].x;
      end else begin
        t = ((stg_q[k-1].prod + RND) >>> FRAC_BITS) + 64'(signed'(row_d[k][ci]));
        stg_d[k].acc = sat32(t);
      end
    end

    // clamp to [0, half wire size]
    half = signed'(row_d[NSTG-1][SLOT_HALF]);
    if (half < 0) half = '0;
    if (stg_q[NSTG-2].acc < 0) stg_d[NSTG-1].acc = '0;
    else if (stg_q[NSTG-2].acc > half) stg_d[NSTG-1].acc = half;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= acc_beat && func_i == FUNC_HIT;
      for (int k = 1; k < NSTG; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NSTG; k++) stg_q[k] <= stg_d[k];
    end
  end

  assign out_valid_o           = vld_q[NSTG-1];
  assign hit_valid_o           = stg_q[NSTG-1].hv;
  assign relative_leading_o    = stg_q[NSTG-1].rel;
  assign time_over_threshold_o = stg_q[NSTG-1].tot;
  assign drift_ns_o            = stg_q[NSTG-1].dt;
  assign drift_length_o        = stg_q[NSTG-1].acc[30:0];

`ifndef ASSERT_OFF
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && func_i != FUNC_HIT) |=> !vld_q[0])
    else $error("write beat entered the hit pipeline");
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[NSTG-2]) |=> out_valid_o)
    else $error("hit lost before the output register");
  a_len_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !stg_q[NSTG-1].acc[31])
    else $error("drift length negative after clamp");
`endif

endmodule
`default_nettype wire
